// ----- rtl/llr_pkg.sv -----
// Package for the leapfrog Lehmer generator: value type, modulus, multiplier
// and the codes for register indexes and item kinds.
// No dependencies; every other file in rtl uses it by scoped names.
package llr_pkg;

    typedef logic [30:0] value_t;

    localparam int VALUE_W = 31;

    // Prime modulus 2^31 - 1 and the base multiplier of the sequence.
    localparam value_t MODULUS     = 31'h7FFF_FFFF;
    localparam value_t LCG_MULT    = 31'd764261123;
    localparam value_t SEED_FACTOR = 31'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_THREAD_COUNT = 2'd0;
    localparam logic [1:0] REG_RANGE_LOW    = 2'd1;
    localparam logic [1:0] REG_RANGE_HIGH   = 2'd2;

    // Item kinds carried on the input tuser.
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

endpackage

// ----- rtl/leapfrog_lehmer_random.sv -----
// Top level of the leapfrog Lehmer generator: control sequencer, registers
// and output register. Depends on llr_pkg, llr_stream_ram, llr_mulmod, llr_scale.
//
// Usage. Items arrive on the s_axis channel: tuser selects a draw or a
// reseed, tdata carries the stream index of a draw. A reseed loads stream i
// with 2 * a^i mod (2^31 - 1) for every i below the thread count and sets the
// leap multiplier to a^count; it gives no result. A draw multiplies the named
// stream by the leap multiplier, stores the new value and returns one transfer
// on m_axis: the raw value and its image in the configured Q16.16 range, or
// zeros with the tuser flag set when the index is not below the thread count.
// Registers are written through the cfg channel, which is always ready; write
// them only while no item is in flight.
// Sequencing. A draw holds the single sequencer through a memory read, the
// modular multiply, the scaling multiply and the quotient stage, and then
// loads its result into the output register; s_axis is ready only while the
// sequencer is idle. A reseed makes one memory write per stream as the
// modular multiplier walks the sequence. A flagged draw skips the memory and
// both multiplies. The output register holds a result while the receiver
// stalls; the next item is still accepted and its sequence stops just before
// the output register until that register is taken.
// Reset clears the registers to count 1 and range 0..1.0 and leaves the
// generator unseeded, so draws return zero until the first reseed. No
// clearing pass runs: a fill count marks which streams have been written.
module leapfrog_lehmer_random #(
    parameter int THREADS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] thread, [7] zero
    input  logic        s_axis_tuser,   // [0] operation
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [30:0] raw_value, [62:31] scaled_value, [63] zero
    output logic        m_axis_tuser,   // [0] bad_thread
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW   = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW   = $clog2(THREADS + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCALE,
        ST_OUT,
        ST_BAD,
        ST_SEED,
        ST_LEAP
    } state_t;

    state_t             state_reg;
    logic [7:0]         thread_count_reg;
    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;
    llr_pkg::value_t    leap_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic [6:0]         thread_reg;
    llr_pkg::value_t    raw_reg;
    logic               out_valid_reg;
    llr_pkg::value_t    out_raw_reg;
    logic signed [31:0] out_scaled_reg;
    logic               out_bad_reg;

    logic [CW-1:0]      count;
    logic [CW-1:0]      idx_next;
    logic               in_fire;
    logic               out_free;
    logic               out_load;
    logic               bad_thread;
    logic               stream_known;
    llr_pkg::value_t    seed_cur;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    llr_pkg::value_t    mem_wr_data;
    llr_pkg::value_t    mem_rd_data;
    logic               mul_en;
    llr_pkg::value_t    mul_a;
    llr_pkg::value_t    mul_b;
    llr_pkg::value_t    mul_result;
    logic signed [31:0] scaled;

    // A count of zero acts as one; a count above the memory depth saturates.
    always_comb
    begin
        if (thread_count_reg == 8'd0)
        begin
            count = CW'(1);
        end
        else if (int'(thread_count_reg) > THREADS)
        begin
            count = CW'(THREADS);
        end
        else
        begin
            count = CW'(thread_count_reg);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = ((state_reg == ST_OUT) || (state_reg == ST_BAD)) && out_free;
    assign bad_thread    = CMPW'(s_axis_tdata[6:0]) >= CMPW'(count);
    assign idx_next      = idx_reg + CW'(1);
    assign cfg_ready     = 1'b1;

    // Streams at or above the fill count were never seeded and read as zero.
    assign stream_known = CMPW'(thread_reg) < CMPW'(fill_reg);
    assign seed_cur     = (idx_reg == '0) ? llr_pkg::SEED_FACTOR : mul_result;

    // The modular multiplier serves both the reseed walk and the draw.
    always_comb
    begin
        mul_en      = 1'b0;
        mul_a       = leap_reg;
        mul_b       = stream_known ? mem_rd_data : '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(thread_reg);
        mem_wr_data = mul_result;
        case (state_reg)
            ST_READ:
            begin
                mul_en = 1'b1;
            end
            ST_WRITE:
            begin
                mem_wr_en = 1'b1;
            end
            ST_SEED:
            begin
                mul_en      = 1'b1;
                mul_a       = llr_pkg::LCG_MULT;
                mul_b       = seed_cur;
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = seed_cur;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    llr_stream_ram #(
        .DEPTH (THREADS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (in_fire),
        .rd_addr (AW'(s_axis_tdata[6:0])),
        .rd_data (mem_rd_data)
    );

    llr_mulmod u_mulmod (
        .clk    (clk),
        .en     (mul_en),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_result)
    );

    llr_scale u_scale (
        .clk        (clk),
        .start      (state_reg == ST_WRITE),
        .raw        (mul_result),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .scaled     (scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thread_count_reg <= 8'd1;
            range_low_reg    <= 32'sd0;
            range_high_reg   <= 32'sd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                llr_pkg::REG_THREAD_COUNT: thread_count_reg <= cfg_data[7:0];
                llr_pkg::REG_RANGE_LOW:    range_low_reg    <= cfg_data;
                llr_pkg::REG_RANGE_HIGH:   range_high_reg   <= cfg_data;
                default:                   thread_count_reg <= thread_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            leap_reg       <= '0;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            thread_reg     <= '0;
            raw_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_raw_reg    <= '0;
            out_scaled_reg <= '0;
            out_bad_reg    <= 1'b0;
        end
        else
        begin
            // A new result may replace the one taken in the same cycle.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        thread_reg <= s_axis_tdata[6:0];
                        cnt_reg    <= count;
                        idx_reg    <= '0;
                        if (s_axis_tuser == llr_pkg::OP_RESEED)
                        begin
                            state_reg <= ST_SEED;
                        end
                        else if (bad_thread)
                        begin
                            state_reg <= ST_BAD;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    raw_reg   <= mul_result;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_raw_reg    <= raw_reg;
                        out_scaled_reg <= scaled;
                        out_bad_reg    <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_BAD:
                begin
                    if (out_free)
                    begin
                        out_raw_reg    <= '0;
                        out_scaled_reg <= '0;
                        out_bad_reg    <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_SEED:
                begin
                    idx_reg <= idx_next;
                    if (idx_next == cnt_reg)
                    begin
                        state_reg <= ST_LEAP;
                    end
                end
                ST_LEAP:
                begin
                    // The walk ends on 2 * a^count; halving modulo 2^31 - 1
                    // is a rotate right by one bit.
                    leap_reg <= {mul_result[0], mul_result[30:1]};
                    if (cnt_reg > fill_reg)
                    begin
                        fill_reg <= cnt_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_scaled_reg, out_raw_reg};
    assign m_axis_tuser  = out_bad_reg;

`ifndef SYNTHESIS
    // The fill count never passes the memory depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(THREADS))
        else $error("fill count above memory depth");

    // The reseed walk stays below the latched count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED) |-> (idx_reg < cnt_reg))
        else $error("reseed index out of range");

    // A finished reseed leaves a nonzero, fully reduced leap multiplier.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEAP) |=> (leap_reg != '0) && (leap_reg != llr_pkg::MODULUS))
        else $error("leap multiplier out of range");

    // A flagged result carries zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("flagged result with nonzero data");

    // Raw values are always reduced below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:0] != llr_pkg::MODULUS))
        else $error("raw value not reduced");
`endif

endmodule

// ----- rtl/llr_stream_ram.sv -----
// Stream state memory of the leapfrog Lehmer generator: one write port and
// one read port, read data registered. Depends on llr_pkg for the value type.
module llr_stream_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  llr_pkg::value_t wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output llr_pkg::value_t rd_data
);

    llr_pkg::value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/llr_mulmod.sv -----
// Multiplier modulo 2^31 - 1: the product is registered and folded on the
// way out. Depends on llr_pkg.
module llr_mulmod (
    input  logic            clk,
    input  logic            en,
    input  llr_pkg::value_t a,
    input  llr_pkg::value_t b,
    output llr_pkg::value_t result
);

    logic [61:0] prod_reg;
    logic [31:0] fold_sum;
    logic [30:0] fold_low;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 62'(a) * 62'(b);
        end
    end

    // Since 2^31 is 1 modulo the prime, the high and low halves add up.
    // A carry out of the first sum wraps around once more; the result can
    // then equal the modulus itself, which stands for zero.
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[61:31]} + {1'b0, prod_reg[30:0]};
        fold_low = fold_sum[30:0] + {30'b0, fold_sum[31]};
        result   = (fold_low == llr_pkg::MODULUS) ? '0 : fold_low;
    end

endmodule

// ----- rtl/llr_scale.sv -----
// Range scaling of the leapfrog Lehmer generator: lo + floor(raw * span /
// (2^31 - 1)) in signed Q16.16 over two registered stages. Depends on llr_pkg.
module llr_scale (
    input  logic               clk,
    input  logic               start,
    input  llr_pkg::value_t    raw,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic signed [31:0] scaled
);

    logic signed [31:0] lo_reg;
    logic [31:0]        span_reg;
    logic [62:0]        prod_reg;
    logic [31:0]        quot_reg;

    logic signed [31:0] lo_ord;
    logic signed [31:0] hi_ord;
    logic [32:0]        part_sum;
    logic [31:0]        rem_sum;
    logic               rem_carry;
    logic [31:0]        quot;

    // Orders bounds from registers the user must change only while idle; unchecked.
    always_comb
    begin
        if (range_low < range_high)
        begin
            lo_ord = range_low;
            hi_ord = range_high;
        end
        else
        begin
            lo_ord = range_high;
            hi_ord = range_low;
        end
    end

    // With x = h * 2^31 + l, x = h * p + (h + l); the remainder term is
    // split once more the same way and needs at most one final correction.
    always_comb
    begin
        part_sum  = {1'b0, prod_reg[62:31]} + {2'b0, prod_reg[30:0]};
        rem_sum   = {1'b0, part_sum[30:0]} + {30'b0, part_sum[32:31]};
        rem_carry = (rem_sum >= {1'b0, llr_pkg::MODULUS});
        quot      = prod_reg[62:31] + {30'b0, part_sum[32:31]} + {31'b0, rem_carry};
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_ord;
        span_reg <= 32'(hi_ord - lo_ord);
        quot_reg <= quot;
        if (start)
        begin
            prod_reg <= 63'(raw) * 63'(span_reg);
        end
    end

    // The true sum lies between the bounds, so a 32-bit wrapping add is exact.
    assign scaled = lo_reg + $signed(quot_reg);

endmodule

// ----- test/leapfrog_lehmer_random_tb.sv -----
// Self-checking testbench for leapfrog_lehmer_random: drives draw and reseed items
// and register writes, and checks every result against its own stream model.
// Depends on llr_pkg and the leapfrog_lehmer_random RTL.
`timescale 1ns / 100ps

module leapfrog_lehmer_random_tb;

    localparam int STREAMS       = 128;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // A reseed walks up to 128 streams and gives no result, so the block may
    // still be busy after the last expected result has come back.
    localparam int SETTLE_CYCLES = 160;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 120;

    typedef enum int {IDLE_NONE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} idle_mode_t;

    typedef struct packed {
        logic [30:0] raw_value;
        logic [31:0] scaled_value;
        logic        bad_thread;
    } draw_result_t;

    // Tracks the generator state and queues the result of every accepted draw.
    class stream_draw_tracker;
        logic [7:0]         count_reg;
        logic signed [31:0] low_reg;
        logic signed [31:0] high_reg;
        llr_pkg::value_t    stream_state [STREAMS];
        llr_pkg::value_t    leap_mult;
        draw_result_t       pending_draws [$];
        int                 mismatches;

        function new();
            count_reg  = 8'd1;
            low_reg    = 32'sd0;
            high_reg   = 32'sd65536;
            leap_mult  = '0;
            mismatches = 0;
            foreach (stream_state[i])
                stream_state[i] = '0;
        endfunction

        static function llr_pkg::value_t mod_mult(llr_pkg::value_t a, llr_pkg::value_t b);
            longint unsigned product;
            product = 64'(a) * 64'(b);
            return llr_pkg::value_t'(product % 64'(llr_pkg::MODULUS));
        endfunction

        function int active_streams();
            if (count_reg == 8'd0)
                return 1;
            if (count_reg > STREAMS)
                return STREAMS;
            return int'(count_reg);
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                llr_pkg::REG_THREAD_COUNT: count_reg = data[7:0];
                llr_pkg::REG_RANGE_LOW:    low_reg   = data;
                llr_pkg::REG_RANGE_HIGH:   high_reg  = data;
                default:                   ;
            endcase
        endfunction

        function void take_item(logic op, logic [6:0] thread);
            int              streams;
            llr_pkg::value_t seq;
            llr_pkg::value_t power;
            llr_pkg::value_t raw;
            longint          lo;
            longint          hi;
            longint unsigned span;
            longint unsigned quotient;
            longint          scaled;
            draw_result_t    result;

            streams = active_streams();
            if (op == llr_pkg::OP_RESEED)
            begin
                // Stream i starts at 2 * a^i, and every stream leaps by a^count.
                seq             = llr_pkg::SEED_FACTOR;
                power           = llr_pkg::LCG_MULT;
                stream_state[0] = seq;
                for (int i = 1; i < streams; i++)
                begin
                    seq             = mod_mult(llr_pkg::LCG_MULT, seq);
                    stream_state[i] = seq;
                    power           = mod_mult(power, llr_pkg::LCG_MULT);
                end
                leap_mult = power;
                return;
            end

            if (int'(thread) >= streams)
            begin
                result = '{raw_value: '0, scaled_value: '0, bad_thread: 1'b1};
            end
            else
            begin
                raw      = mod_mult(leap_mult, stream_state[thread]);
                lo       = (low_reg < high_reg) ? longint'(low_reg) : longint'(high_reg);
                hi       = (low_reg < high_reg) ? longint'(high_reg) : longint'(low_reg);
                span     = longint'(hi - lo);
                quotient = (64'(raw) * span) / 64'(llr_pkg::MODULUS);
                scaled   = lo + longint'(quotient);
                stream_state[thread] = raw;
                result = '{raw_value: raw, scaled_value: scaled[31:0], bad_thread: 1'b0};
            end
            pending_draws.push_back(result);
        endfunction

        function void check_draw(logic [30:0] raw, logic [31:0] scaled, logic bad);
            draw_result_t want;

            if (pending_draws.size() == 0)
            begin
                $error("result transfer with nothing expected: raw_value %0d", raw);
                mismatches++;
                return;
            end
            want = pending_draws.pop_front();
            if (raw !== want.raw_value)
            begin
                $error("raw_value: expected %0d, got %0d", want.raw_value, raw);
                mismatches++;
            end
            if (scaled !== want.scaled_value)
            begin
                $error("scaled_value: expected %0d, got %0d",
                       $signed(want.scaled_value), $signed(scaled));
                mismatches++;
            end
            if (bad !== want.bad_thread)
            begin
                $error("bad_thread: expected %0d, got %0d", want.bad_thread, bad);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    stream_draw_tracker tracker;
    idle_mode_t         idle_mode;
    int                 cycle_count;

    leapfrog_lehmer_random #(
        .THREADS (STREAMS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls at random in the phases that call for it.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            case (idle_mode)
                RECEIVER_STALL: m_axis_tready <= ($urandom_range(99) >= 62);
                BOTH_IDLE:      m_axis_tready <= ($urandom_range(99) >= 22);
                default:        m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Every transfer is observed here, with the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_item(s_axis_tuser, s_axis_tdata[6:0]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_draw(m_axis_tdata[30:0], m_axis_tdata[62:31], m_axis_tuser);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("leapfrog_lehmer_random_tb: errors");
        $finish;
    end

    function automatic int effective_streams(logic [7:0] count);
        if (count == 8'd0)
            return 1;
        if (count > STREAMS)
            return STREAMS;
        return int'(count);
    endfunction

    // A range bound: the extremes, zero, a small Q16.16 value or anything.
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    // Holds the item until its transfer; the valid stays high for the next
    // item unless a random gap comes first.
    task automatic send_item(input logic op, input logic [6:0] thread);
        int unsigned idle_pct;

        case (idle_mode)
            SENDER_IDLE: idle_pct = 62;
            BOTH_IDLE:   idle_pct = 22;
            default:     idle_pct = 0;
        endcase
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, thread};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [7:0] count, input logic [31:0] low,
                                input logic [31:0] high);
        write_reg(llr_pkg::REG_THREAD_COUNT, {24'd0, count});
        write_reg(llr_pkg::REG_RANGE_LOW, low);
        write_reg(llr_pkg::REG_RANGE_HIGH, high);
        cfg_valid <= 1'b0;
    endtask

    // Drains the block: every expected result back, then time for a reseed
    // that may still be walking the streams.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  count;
        int          streams;
        int unsigned roll;

        tracker   = new();
        idle_mode = IDLE_NONE;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= llr_pkg::OP_DRAW;
        cfg_valid     <= 1'b0;
        cfg_index     <= llr_pkg::REG_THREAD_COUNT;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: one stream, range 0..1.0, unseeded, so a draw gives zero.
        send_item(llr_pkg::OP_DRAW, 7'd0);
        send_item(llr_pkg::OP_DRAW, 7'd1);
        send_item(llr_pkg::OP_DRAW, 7'd127);
        settle();

        // Widest range and all streams, with one draw before seeding.
        program_regs(8'd128, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(llr_pkg::OP_DRAW, 7'd5);
        send_item(llr_pkg::OP_RESEED, 7'($urandom()));
        send_item(llr_pkg::OP_DRAW, 7'd0);
        send_item(llr_pkg::OP_DRAW, 7'd127);
        send_item(llr_pkg::OP_DRAW, 7'd127);
        send_item(llr_pkg::OP_DRAW, 7'd64);
        settle();

        // Bounds given in reverse order; a smaller reseed leaves upper streams alone.
        program_regs(8'd4, 32'h0005_0000, 32'hFFFD_0000);
        send_item(llr_pkg::OP_RESEED, 7'($urandom()));
        send_item(llr_pkg::OP_DRAW, 7'd3);
        send_item(llr_pkg::OP_DRAW, 7'd4);
        send_item(llr_pkg::OP_DRAW, 7'd0);
        settle();

        // A count of zero acts as one; equal bounds leave no span.
        program_regs(8'd0, 32'h0001_2345, 32'h0001_2345);
        send_item(llr_pkg::OP_DRAW, 7'd0);
        send_item(llr_pkg::OP_DRAW, 7'd1);
        send_item(llr_pkg::OP_RESEED, 7'($urandom()));
        send_item(llr_pkg::OP_DRAW, 7'd0);
        settle();

        // A count above the stream total saturates; no reseed, so the leap stays.
        program_regs(8'd255, 32'h8000_0000, 32'h8000_0001);
        send_item(llr_pkg::OP_DRAW, 7'd127);
        send_item(llr_pkg::OP_DRAW, 7'd100);
        settle();

        // Random phases: mostly seeded draws on valid streams, some reseeds and
        // some indexes beyond the count, under each idling pattern in turn.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            case (phase)
                0:       count = 8'd1;
                1:       count = 8'd128;
                2:       count = 8'd0;
                3:       count = 8'd255;
                4, 5:    count = 8'($urandom_range(8, 1));
                default: count = 8'($urandom_range(255));
            endcase
            program_regs(count, pick_bound(), pick_bound());
            streams = effective_streams(count);

            if ($urandom_range(9) < 8)
                send_item(llr_pkg::OP_RESEED, 7'($urandom()));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    send_item(llr_pkg::OP_RESEED, 7'($urandom()));
                else if (roll < 12 && streams < STREAMS)
                    send_item(llr_pkg::OP_DRAW, 7'($urandom_range(STREAMS - 1, streams)));
                else if (roll < 16)
                    send_item(llr_pkg::OP_DRAW, 7'($urandom()));
                else
                    send_item(llr_pkg::OP_DRAW, 7'($urandom_range(streams - 1, 0)));
            end
            settle();
        end

        if (tracker.mismatches == 0)
            $display("leapfrog_lehmer_random_tb: clean");
        else
            $display("leapfrog_lehmer_random_tb: errors");
        $finish;
    end

endmodule
